// ===== design/grid_astar_search_core_assert.svh =====
// assertion macros for the grid search core
`ifndef GRID_ASTAR_SEARCH_CORE_ASSERT_SVH
`define GRID_ASTAR_SEARCH_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define GAS_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grid search check failed");
`define GAS_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grid search check failed");
`else
`define GAS_ASSERT_IMP(name, ante, cons)
`define GAS_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ===== design/gas_pkg.sv =====
`timescale 1ns / 1ps
package gas_pkg;

    localparam logic [1:0] MODE_LOAD   = 2'd0;
    localparam logic [1:0] MODE_SEARCH = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [2:0] CELL_EMPTY  = 3'd0;
    localparam logic [2:0] CELL_OBST   = 3'd1;
    localparam logic [2:0] CELL_CLOSED = 3'd2;
    localparam logic [2:0] CELL_PATH   = 3'd3;
    localparam logic [2:0] CELL_START  = 3'd4;
    localparam logic [2:0] CELL_FINISH = 3'd5;

    localparam logic KIND_SEARCH = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    localparam logic [2:0] REG_ROWS_USED = 3'd0;
    localparam logic [2:0] REG_COLS_USED = 3'd1;
    localparam logic [2:0] REG_START_ROW = 3'd2;
    localparam logic [2:0] REG_START_COL = 3'd3;
    localparam logic [2:0] REG_GOAL_ROW  = 3'd4;
    localparam logic [2:0] REG_GOAL_COL  = 3'd5;

    localparam logic [4:0] OP_NONE       = 5'd0;
    localparam logic [4:0] OP_CLR        = 5'd1;
    localparam logic [4:0] OP_LOAD       = 5'd2;
    localparam logic [4:0] OP_RDCELL     = 5'd3;
    localparam logic [4:0] OP_RDOUT      = 5'd4;
    localparam logic [4:0] OP_SINIT      = 5'd5;
    localparam logic [4:0] OP_PUSH_START = 5'd6;
    localparam logic [4:0] OP_SCAN_INIT  = 5'd7;
    localparam logic [4:0] OP_SCAN       = 5'd8;
    localparam logic [4:0] OP_POP        = 5'd9;
    localparam logic [4:0] OP_SH_RD      = 5'd10;
    localparam logic [4:0] OP_SH_WR      = 5'd11;
    localparam logic [4:0] OP_FIN_START  = 5'd12;
    localparam logic [4:0] OP_FIN_GOAL   = 5'd13;
    localparam logic [4:0] OP_NB_RD      = 5'd14;
    localparam logic [4:0] OP_NB_CHK     = 5'd15;
    localparam logic [4:0] OP_DONE       = 5'd16;

    typedef struct packed {
        logic [4:0] op;
        logic       take;
    } cmd_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       clr_last;
        logic       start_out;
        logic       scan_last;
        logic       cur_goal;
        logic       sh_done;
        logic       dir_last;
        logic       open_empty;
        logic       out_free;
    } stat_t;

endpackage

// ===== design/gas_ram.sv =====
`timescale 1ns / 1ps
module gas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/gas_ctrl.sv =====
`timescale 1ns / 1ps
module gas_ctrl
    import gas_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  stat_t stat,
    output cmd_t  cmd,
    output logic  busy
);

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_DISP  = 5'd2;
    localparam logic [4:0] S_RDOUT = 5'd3;
    localparam logic [4:0] S_PUSH0 = 5'd4;
    localparam logic [4:0] S_SCAN0 = 5'd5;
    localparam logic [4:0] S_SCAN  = 5'd6;
    localparam logic [4:0] S_POP   = 5'd7;
    localparam logic [4:0] S_SHRD  = 5'd8;
    localparam logic [4:0] S_SHWR  = 5'd9;
    localparam logic [4:0] S_FINS  = 5'd10;
    localparam logic [4:0] S_FING  = 5'd11;
    localparam logic [4:0] S_NBRD  = 5'd12;
    localparam logic [4:0] S_NBCHK = 5'd13;
    localparam logic [4:0] S_DONE  = 5'd14;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.take   = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.op = OP_CLR;
                if (stat.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.take = in_valid;
                if (in_valid)
                begin
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (stat.mode)
                    MODE_LOAD:
                    begin
                        cmd.op     = OP_LOAD;
                        state_next = S_IDLE;
                    end
                    MODE_SEARCH:
                    begin
                        cmd.op     = OP_SINIT;
                        state_next = S_PUSH0;
                    end
                    MODE_READ:
                    begin
                        cmd.op     = OP_RDCELL;
                        state_next = S_RDOUT;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_RDOUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_RDOUT;
                    state_next = S_IDLE;
                end
            end
            S_PUSH0:
            begin
                if (stat.start_out)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_PUSH_START;
                    state_next = S_SCAN0;
                end
            end
            S_SCAN0:
            begin
                if (stat.open_empty)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.op     = OP_SCAN_INIT;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (stat.scan_last)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                cmd.op     = OP_POP;
                state_next = stat.cur_goal ? S_FINS : S_SHRD;
            end
            S_SHRD:
            begin
                if (stat.sh_done)
                begin
                    state_next = S_NBRD;
                end
                else
                begin
                    cmd.op     = OP_SH_RD;
                    state_next = S_SHWR;
                end
            end
            S_SHWR:
            begin
                cmd.op     = OP_SH_WR;
                state_next = S_SHRD;
            end
            S_FINS:
            begin
                cmd.op     = OP_FIN_START;
                state_next = S_FING;
            end
            S_FING:
            begin
                cmd.op     = OP_FIN_GOAL;
                state_next = S_DONE;
            end
            S_NBRD:
            begin
                cmd.op     = OP_NB_RD;
                state_next = S_NBCHK;
            end
            S_NBCHK:
            begin
                cmd.op     = OP_NB_CHK;
                state_next = stat.dir_last ? S_SCAN0 : S_NBRD;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_DONE;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/gas_datapath.sv =====
`timescale 1ns / 1ps
`include "grid_astar_search_core_assert.svh"
module gas_datapath
    import gas_pkg::*;
#(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int OPEN_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    output stat_t      stat,
    input  logic [4:0] rows_used,
    input  logic [4:0] cols_used,
    input  logic [3:0] start_row,
    input  logic [3:0] start_col,
    input  logic [3:0] goal_row,
    input  logic [3:0] goal_col,
    input  logic [1:0] mode,
    input  logic [3:0] row,
    input  logic [3:0] col,
    input  logic       blocked,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic       found,
    output logic [2:0] cell_code,
    output logic [8:0] expanded
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RB    = $clog2(MAX_ROWS);
    localparam int CB    = $clog2(MAX_COLS);
    localparam int GW    = AW + 1;
    localparam int EW    = RB + CB + GW;
    localparam int OIW   = $clog2(OPEN_DEPTH);
    localparam int OCW   = $clog2(OPEN_DEPTH + 1);
    localparam int RC    = (RB > CB) ? RB : CB;
    localparam int CW    = (RC > 4) ? RC : 4;
    localparam int FW    = ((GW > CW + 1) ? GW : CW + 1) + 1;

    function automatic logic [AW-1:0] gaddr(input logic [RB-1:0] r, input logic [CB-1:0] c);
        gaddr = AW'(r * MAX_COLS + c);
    endfunction

    // item fields
    logic [1:0]     item_mode_reg;
    logic [3:0]     item_row_reg;
    logic [3:0]     item_col_reg;
    logic           item_blk_reg;

    logic [AW-1:0]  clr_ptr_reg;
    logic [OCW-1:0] count_reg;
    logic [8:0]     exp_reg;
    logic           found_reg;
    logic [OIW-1:0] ptr_reg;
    logic [OIW-1:0] best_reg;
    logic [FW-1:0]  bestf_reg;
    logic [RB-1:0]  cur_r_reg;
    logic [CB-1:0]  cur_c_reg;
    logic [GW-1:0]  cur_g_reg;
    logic [OCW-1:0] sh_reg;
    logic [1:0]     dir_reg;
    logic [RB-1:0]  nb_r_reg;
    logic [CB-1:0]  nb_c_reg;
    logic           nb_inb_reg;

    logic           out_valid_reg;
    logic           kind_reg;
    logic           ofound_reg;
    logic [2:0]     code_reg;
    logic [8:0]     oexp_reg;

    logic [4:0]     rows_lim;
    logic [4:0]     cols_lim;
    logic           item_in;
    logic [AW-1:0]  item_addr;
    logic [AW-1:0]  start_addr;
    logic [AW-1:0]  cur_addr;

    logic           g_we;
    logic [AW-1:0]  g_waddr;
    logic [2:0]     g_wdata;
    logic           g_re;
    logic [AW-1:0]  g_raddr;
    logic [2:0]     g_rdata;

    logic           o_we;
    logic [OIW-1:0] o_waddr;
    logic [EW-1:0]  o_wdata;
    logic           o_re;
    logic [OIW-1:0] o_raddr;
    logic [EW-1:0]  o_rdata;

    logic [RB-1:0]  ent_r;
    logic [CB-1:0]  ent_c;
    logic [GW-1:0]  ent_g;
    logic [CW-1:0]  ent_dr;
    logic [CW-1:0]  ent_dc;
    logic [FW-1:0]  ent_f;

    logic [RB-1:0]  nb_r;
    logic [CB-1:0]  nb_c;
    logic           nb_inb;
    logic           push_ok;
    logic           room;
    logic           out_free;

    assign rows_lim = (32'(rows_used) > 32'(MAX_ROWS)) ? 5'(MAX_ROWS) : rows_used;
    assign cols_lim = (32'(cols_used) > 32'(MAX_COLS)) ? 5'(MAX_COLS) : cols_used;
    assign item_in  = (32'(item_row_reg) < 32'(MAX_ROWS)) && (32'(item_col_reg) < 32'(MAX_COLS));
    assign item_addr  = gaddr(RB'(item_row_reg), CB'(item_col_reg));
    assign start_addr = gaddr(RB'(start_row), CB'(start_col));
    assign cur_addr   = gaddr(cur_r_reg, cur_c_reg);

    assign ent_r = o_rdata[EW-1 -: RB];
    assign ent_c = o_rdata[GW +: CB];
    assign ent_g = o_rdata[GW-1:0];

    // f = g + manhattan distance to the goal
    always_comb
    begin
        ent_dr = (CW'(ent_r) > CW'(goal_row)) ? CW'(ent_r) - CW'(goal_row)
                                              : CW'(goal_row) - CW'(ent_r);
        ent_dc = (CW'(ent_c) > CW'(goal_col)) ? CW'(ent_c) - CW'(goal_col)
                                              : CW'(goal_col) - CW'(ent_c);
        ent_f  = FW'(ent_g) + FW'(ent_dr) + FW'(ent_dc);
    end

    // neighbour order: up, left, down, right
    always_comb
    begin
        nb_r   = cur_r_reg;
        nb_c   = cur_c_reg;
        nb_inb = 1'b0;
        case (dir_reg)
            2'd0:
            begin
                nb_r   = cur_r_reg - 1'b1;
                nb_inb = (cur_r_reg != '0);
            end
            2'd1:
            begin
                nb_c   = cur_c_reg - 1'b1;
                nb_inb = (cur_c_reg != '0);
            end
            2'd2:
            begin
                nb_r   = cur_r_reg + 1'b1;
                nb_inb = (32'(cur_r_reg) + 32'd1 < 32'(rows_lim));
            end
            default:
            begin
                nb_c   = cur_c_reg + 1'b1;
                nb_inb = (32'(cur_c_reg) + 32'd1 < 32'(cols_lim));
            end
        endcase
    end

    assign room     = (32'(count_reg) < 32'(OPEN_DEPTH));
    assign push_ok  = nb_inb_reg && (g_rdata == CELL_EMPTY) && room;
    assign out_free = !out_valid_reg || !out_stall;

    // grid port selection
    always_comb
    begin
        g_we    = 1'b0;
        g_waddr = cur_addr;
        g_wdata = CELL_EMPTY;
        g_re    = 1'b0;
        g_raddr = item_addr;
        unique case (cmd.op)
            OP_CLR:
            begin
                g_we    = 1'b1;
                g_waddr = clr_ptr_reg;
            end
            OP_LOAD:
            begin
                g_we    = item_in;
                g_waddr = item_addr;
                g_wdata = item_blk_reg ? CELL_OBST : CELL_EMPTY;
            end
            OP_RDCELL:
            begin
                g_re = 1'b1;
            end
            OP_PUSH_START:
            begin
                g_we    = 1'b1;
                g_waddr = start_addr;
                g_wdata = CELL_CLOSED;
            end
            OP_POP:
            begin
                g_we    = 1'b1;
                g_wdata = CELL_PATH;
            end
            OP_FIN_START:
            begin
                g_we    = 1'b1;
                g_waddr = start_addr;
                g_wdata = CELL_START;
            end
            OP_FIN_GOAL:
            begin
                g_we    = 1'b1;
                g_wdata = CELL_FINISH;
            end
            OP_NB_RD:
            begin
                g_re    = 1'b1;
                g_raddr = gaddr(nb_r, nb_c);
            end
            OP_NB_CHK:
            begin
                g_we    = push_ok;
                g_waddr = gaddr(nb_r_reg, nb_c_reg);
                g_wdata = CELL_CLOSED;
            end
            default:
            begin
                g_we = 1'b0;
            end
        endcase
    end

    // open list port selection
    always_comb
    begin
        o_we    = 1'b0;
        o_waddr = OIW'(count_reg);
        o_wdata = {RB'(start_row), CB'(start_col), GW'(0)};
        o_re    = 1'b0;
        o_raddr = '0;
        unique case (cmd.op)
            OP_PUSH_START:
            begin
                o_we = 1'b1;
            end
            OP_NB_CHK:
            begin
                o_we    = push_ok;
                o_wdata = {nb_r_reg, nb_c_reg, cur_g_reg + 1'b1};
            end
            OP_SH_WR:
            begin
                o_we    = 1'b1;
                o_waddr = OIW'(sh_reg);
                o_wdata = o_rdata;
            end
            OP_SCAN_INIT:
            begin
                o_re = 1'b1;
            end
            OP_SCAN:
            begin
                o_re    = 1'b1;
                o_raddr = ptr_reg + 1'b1;
            end
            OP_SH_RD:
            begin
                o_re    = 1'b1;
                o_raddr = OIW'(sh_reg + 1'b1);
            end
            default:
            begin
                o_we = 1'b0;
            end
        endcase
    end

    gas_ram #(
        .WIDTH(3),
        .DEPTH(CELLS)
    ) u_grid (
        .clk  (clk),
        .we   (g_we),
        .waddr(g_waddr),
        .wdata(g_wdata),
        .re   (g_re),
        .raddr(g_raddr),
        .rdata(g_rdata)
    );

    gas_ram #(
        .WIDTH(EW),
        .DEPTH(OPEN_DEPTH)
    ) u_open (
        .clk  (clk),
        .we   (o_we),
        .waddr(o_waddr),
        .wdata(o_wdata),
        .re   (o_re),
        .raddr(o_raddr),
        .rdata(o_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_ptr_reg   <= '0;
            count_reg     <= '0;
            exp_reg       <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            item_mode_reg <= MODE_LOAD;
        end
        else
        begin
            if (cmd.take)
            begin
                item_mode_reg <= mode;
            end
            if (cmd.op == OP_RDOUT || cmd.op == OP_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_CLR:
                begin
                    clr_ptr_reg <= clr_ptr_reg + 1'b1;
                end
                OP_SINIT:
                begin
                    count_reg <= '0;
                    exp_reg   <= '0;
                    found_reg <= 1'b0;
                end
                OP_PUSH_START:
                begin
                    count_reg <= count_reg + 1'b1;
                end
                OP_POP:
                begin
                    count_reg <= count_reg - 1'b1;
                    if (exp_reg != 9'h1ff)
                    begin
                        exp_reg <= exp_reg + 1'b1;
                    end
                end
                OP_NB_CHK:
                begin
                    if (push_ok)
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                OP_FIN_GOAL:
                begin
                    found_reg <= 1'b1;
                end
                default:
                begin
                    found_reg <= found_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            item_row_reg <= row;
            item_col_reg <= col;
            item_blk_reg <= blocked;
        end
        unique case (cmd.op)
            OP_SCAN_INIT:
            begin
                ptr_reg <= '0;
            end
            OP_SCAN:
            begin
                ptr_reg <= ptr_reg + 1'b1;
                // ties go to the later entry
                if (ptr_reg == '0 || ent_f <= bestf_reg)
                begin
                    best_reg  <= ptr_reg;
                    bestf_reg <= ent_f;
                    cur_r_reg <= ent_r;
                    cur_c_reg <= ent_c;
                    cur_g_reg <= ent_g;
                end
            end
            OP_POP:
            begin
                sh_reg  <= OCW'(best_reg);
                dir_reg <= 2'd0;
            end
            OP_SH_WR:
            begin
                sh_reg <= sh_reg + 1'b1;
            end
            OP_NB_RD:
            begin
                nb_r_reg   <= nb_r;
                nb_c_reg   <= nb_c;
                nb_inb_reg <= nb_inb;
            end
            OP_NB_CHK:
            begin
                dir_reg <= dir_reg + 1'b1;
            end
            OP_RDOUT:
            begin
                kind_reg   <= KIND_READ;
                ofound_reg <= 1'b0;
                code_reg   <= item_in ? g_rdata : CELL_EMPTY;
                oexp_reg   <= '0;
            end
            OP_DONE:
            begin
                kind_reg   <= KIND_SEARCH;
                ofound_reg <= found_reg;
                code_reg   <= CELL_EMPTY;
                oexp_reg   <= exp_reg;
            end
            default:
            begin
                ptr_reg <= ptr_reg;
            end
        endcase
    end

    assign stat.mode       = item_mode_reg;
    assign stat.clr_last   = (clr_ptr_reg == AW'(CELLS - 1));
    assign stat.start_out  = !((32'(start_row) < 32'(rows_lim)) &&
                               (32'(start_col) < 32'(cols_lim)));
    assign stat.scan_last  = (OCW'(ptr_reg) + 1'b1 == count_reg);
    assign stat.cur_goal   = (32'(cur_r_reg) == 32'(goal_row)) &&
                             (32'(cur_c_reg) == 32'(goal_col));
    assign stat.sh_done    = !(sh_reg < count_reg);
    assign stat.dir_last   = (dir_reg == 2'd3);
    assign stat.open_empty = (count_reg == '0);
    assign stat.out_free   = out_free;

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign found     = ofound_reg;
    assign cell_code = code_reg;
    assign expanded  = oexp_reg;

    `GAS_ASSERT_IMP(a_count_bound, 1'b1, 32'(count_reg) <= 32'(OPEN_DEPTH))
    `GAS_ASSERT_IMP(a_pop_nonempty, cmd.op == OP_POP, count_reg != '0)
    `GAS_ASSERT_IMP(a_no_overwrite, cmd.op == OP_DONE || cmd.op == OP_RDOUT, out_free)
    `GAS_ASSERT_IMP(a_finish_on_goal, cmd.op == OP_FIN_GOAL, stat.cur_goal)
    `GAS_ASSERT_NXT(a_done_found, cmd.op == OP_FIN_GOAL, found_reg)

endmodule

// ===== design/grid_astar_search_core.sv =====
`timescale 1ns / 1ps
// load: take the item, then write its grid cell; read: read the grid cell, then register
// the result word once the output is free; search: per expansion, a serial scan of the open
// list memory for the least f, one entry a cycle, then the pop, shift and neighbour checks
// one item in flight at a time; a finished result may wait while the next item is taken
// reset: async, active low; then a clearing pass over all MAX_ROWS * MAX_COLS cells
// zeroes the grid memory while no item is accepted
module grid_astar_search_core
    import gas_pkg::*;
#(
    parameter int MAX_ROWS   = 16,
    parameter int MAX_COLS   = 16,
    parameter int OPEN_DEPTH = 256
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_index,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] mode,
    input  logic [3:0] row,
    input  logic [3:0] col,
    input  logic       blocked,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       kind,
    output logic       found,
    output logic [2:0] cell_code,
    output logic [8:0] expanded
);

    logic [4:0] rows_used_reg;
    logic [4:0] cols_used_reg;
    logic [3:0] start_row_reg;
    logic [3:0] start_col_reg;
    logic [3:0] goal_row_reg;
    logic [3:0] goal_col_reg;

    cmd_t  cmd;
    stat_t stat;
    logic  busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_used_reg <= 5'd16;
            cols_used_reg <= 5'd16;
            start_row_reg <= 4'd0;
            start_col_reg <= 4'd0;
            goal_row_reg  <= 4'd4;
            goal_col_reg  <= 4'd5;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROWS_USED: rows_used_reg <= cfg_data;
                REG_COLS_USED: cols_used_reg <= cfg_data;
                REG_START_ROW: start_row_reg <= cfg_data[3:0];
                REG_START_COL: start_col_reg <= cfg_data[3:0];
                REG_GOAL_ROW:  goal_row_reg  <= cfg_data[3:0];
                REG_GOAL_COL:  goal_col_reg  <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign in_stall = busy;

    gas_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(in_valid),
        .stat    (stat),
        .cmd     (cmd),
        .busy    (busy)
    );

    gas_datapath #(
        .MAX_ROWS  (MAX_ROWS),
        .MAX_COLS  (MAX_COLS),
        .OPEN_DEPTH(OPEN_DEPTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .rows_used(rows_used_reg),
        .cols_used(cols_used_reg),
        .start_row(start_row_reg),
        .start_col(start_col_reg),
        .goal_row (goal_row_reg),
        .goal_col (goal_col_reg),
        .mode     (mode),
        .row      (row),
        .col      (col),
        .blocked  (blocked),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .kind     (kind),
        .found    (found),
        .cell_code(cell_code),
        .expanded (expanded)
    );

endmodule
